// ===== hdl/acdc_nls_pkg.sv =====
package acdc_nls_pkg;

  localparam int unsigned MAX_MB_WIDTH_DEF = 128;
  localparam int unsigned COEFS_PER_BLOCK  = 16;

  localparam int unsigned COEF_W     = $clog2(COEFS_PER_BLOCK);
  localparam int unsigned POS_W      = 14;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned MBW_W      = 8;
  localparam int unsigned PXB_W      = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MB_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BITS = 1'b1;

  localparam logic [MBW_W-1:0] MB_WIDTH_RST   = 8'd22;
  localparam logic [PXB_W-1:0] PIXEL_BITS_RST = 4'd8;
  localparam logic [PXB_W-1:0] PIXEL_BITS_MAX = 4'd12;

  localparam logic [COEF_W-1:0] DC_INDEX   = '0;
  localparam logic [COEF_W-1:0] LAST_INDEX = '1;

  typedef struct packed {
    logic [POS_W-1:0]         mb_position;
    logic                     resync;
    logic [COEF_W-1:0]        coef_index;
    logic signed [DATA_W-1:0] prev_block1_coef;
    logic signed [DATA_W-1:0] prev_block2_coef;
    logic signed [DATA_W-1:0] prev_block3_coef;
  } in_t;

  typedef struct packed {
    logic [COEF_W-1:0]        out_index;
    logic signed [DATA_W-1:0] left_top_coef;
    logic signed [DATA_W-1:0] above_left_coef;
    logic signed [DATA_W-1:0] above_coef;
    logic signed [DATA_W-1:0] above_right_coef;
    logic signed [DATA_W-1:0] left_bottom_coef;
    logic                     last;
  } out_t;

  // status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // default DC neighbour, 2^(bits+2), bits saturated at twelve
  function automatic logic [DATA_W-1:0] default_dc(input logic [PXB_W-1:0] bits);
    logic [PXB_W-1:0] b;
    b = (bits > PIXEL_BITS_MAX) ? PIXEL_BITS_MAX : bits;
    return DATA_W'(1) << ({1'b0, b} + 5'd2);
  endfunction

endpackage

// ===== hdl/acdc_nls_ram.sv =====
module acdc_nls_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4112,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/acdc_nls_mod_unit.sv =====
module acdc_nls_mod_unit #(
  parameter int unsigned DVD_W = 14,
  parameter int unsigned DVS_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DVD_W-1:0]        dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output acdc_nls_pkg::div_stat_t stat_o,
  output logic [DVS_W-1:0]        rem_o
);

  import acdc_nls_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] trial_sub;
  logic           take;

  // restoring step: shift one dividend bit into the partial remainder
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    take      = trial >= {1'b0, dvs_q};
    trial_sub = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? DVS_W'(trial_sub) : DVS_W'(trial);
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

  // no restart while a remainder is being worked out
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("remainder unit restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("remainder done without a running step");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && dvs_q != '0) |=> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

endmodule

// ===== hdl/acdc_neighbor_line_store_core.sv =====
// Channel | Dir | Handshake             | Payload
// --------+-----+-----------------------+---------------------------------
// in      | in  | in_valid_i/in_stall_o | in_data_i (coef of blocks 1..3)
// out     | out | out_valid_o/out_stall_i | out_data_o (neighbours A..E)
// cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// A normal transaction runs the bit-serial remainder unit (one quotient bit per
// cycle over 14 position bits), then makes five accesses to the single-read,
// single-write line store, then loads the result register once the output is free.
// A resync transaction loads its result first and then sweeps the store, one entry
// a cycle, over 2*MAX_MB_WIDTH*16+16 entries (4112 at the default); reset starts the
// same sweep. No input is taken during a sweep; config writes are.
// The result register lets the next input be taken while a result is stalled.
module acdc_neighbor_line_store_core #(
  parameter int unsigned MAX_MB_WIDTH = acdc_nls_pkg::MAX_MB_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  acdc_nls_pkg::in_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output acdc_nls_pkg::out_t                     out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [acdc_nls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [acdc_nls_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import acdc_nls_pkg::*;

  localparam int unsigned NUM_BLOCKS  = 2 * MAX_MB_WIDTH + 1;
  localparam int unsigned STORE_DEPTH = NUM_BLOCKS * COEFS_PER_BLOCK;
  localparam int unsigned BLK_W       = $clog2(NUM_BLOCKS);
  localparam int unsigned ADDR_W      = BLK_W + COEF_W;
  localparam int unsigned WID_W       = $clog2(MAX_MB_WIDTH + 1);
  localparam int unsigned COL_W       = (MAX_MB_WIDTH > 1) ? $clog2(MAX_MB_WIDTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_WR_LO,
    ST_WR_HI,
    ST_RESULT,
    ST_CLEAR
  } state_e;

  state_e state_q;

  logic [MBW_W-1:0]  mb_width_q;
  logic [PXB_W-1:0]  pixel_bits_q;

  in_t               item_q;
  logic [WID_W-1:0]  w_q;
  logic [DATA_W-1:0] def_q;
  logic [DATA_W-1:0] clr_dc_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] c_q;
  logic [DATA_W-1:0] d_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              in_accept;
  logic              out_free;
  logic              out_load;
  logic [WID_W-1:0]  w_eff;
  logic [DATA_W-1:0] dc_now;

  div_stat_t         div_stat;
  logic [WID_W-1:0]  div_rem;
  logic              div_start;
  logic [COL_W-1:0]  col;
  logic              col_nz;

  logic [BLK_W-1:0]  blk_b;
  logic [BLK_W-1:0]  blk_w2;
  logic [BLK_W-1:0]  blk_lo;
  logic [BLK_W-1:0]  blk_hi;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_RESULT) && out_free;
  assign dc_now     = default_dc(pixel_bits_q);

  // width clamped to 1..MAX_MB_WIDTH
  always_comb begin
    logic [MBW_W:0] mbw;
    mbw = {1'b0, mb_width_q};
    if (mbw == '0) begin
      w_eff = WID_W'(1);
    end else if (mbw > (MBW_W + 1)'(MAX_MB_WIDTH)) begin
      w_eff = WID_W'(MAX_MB_WIDTH);
    end else begin
      w_eff = WID_W'(mbw);
    end
  end

  assign div_start = in_accept && !in_data_i.resync;

  acdc_nls_mod_unit #(
    .DVD_W(POS_W),
    .DVS_W(WID_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(in_data_i.mb_position),
    .divisor_i (w_eff),
    .stat_o    (div_stat),
    .rem_o     (div_rem)
  );

  // remainder stays below the width, so it fits the column index
  assign col    = COL_W'(div_rem);
  assign col_nz = (col != '0);

  always_comb begin
    blk_b  = BLK_W'({col, 1'b0});
    blk_w2 = BLK_W'({w_q, 1'b0});
    // the first column writes the wrap-around slots at the row end
    blk_lo = col_nz ? (blk_b - BLK_W'(1)) : (blk_w2 - BLK_W'(1));
    blk_hi = col_nz ? blk_b : blk_w2;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      ST_RD_B: begin
        ram_re    = 1'b1;
        ram_raddr = {blk_b, item_q.coef_index};
      end
      ST_RD_C: begin
        ram_re    = 1'b1;
        ram_raddr = {blk_b + BLK_W'(1), item_q.coef_index};
      end
      ST_RD_D: begin
        ram_re    = 1'b1;
        ram_raddr = {blk_b + BLK_W'(2), item_q.coef_index};
      end
      ST_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = {blk_lo, item_q.coef_index};
        ram_wdata = item_q.prev_block2_coef;
      end
      ST_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = {blk_hi, item_q.coef_index};
        ram_wdata = item_q.prev_block3_coef;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = (clr_cnt_q[COEF_W-1:0] == DC_INDEX) ? clr_dc_q : '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  acdc_nls_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_width_q   <= MB_WIDTH_RST;
      pixel_bits_q <= PIXEL_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MB_WIDTH:   mb_width_q   <= cfg_wdata_i;
        CFG_PIXEL_BITS: pixel_bits_q <= PXB_W'(cfg_wdata_i);
        default:        mb_width_q   <= mb_width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_dc_q    <= default_dc(PIXEL_BITS_RST);
      out_valid_q <= 1'b0;
      out_q       <= '0;
      item_q      <= '0;
      w_q         <= '0;
      def_q       <= '0;
      b_q         <= '0;
      c_q         <= '0;
      d_q         <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            item_q  <= in_data_i;
            w_q     <= w_eff;
            def_q   <= (in_data_i.coef_index == DC_INDEX) ? dc_now : '0;
            state_q <= in_data_i.resync ? ST_RESULT : ST_MOD;
            if (in_data_i.resync) begin
              clr_dc_q  <= dc_now;
              clr_cnt_q <= '0;
            end
          end
        end
        ST_MOD: begin
          if (div_stat.done) begin
            state_q <= ST_RD_B;
          end
        end
        ST_RD_B: state_q <= ST_RD_C;
        ST_RD_C: begin
          b_q     <= ram_rdata;
          state_q <= ST_RD_D;
        end
        ST_RD_D: begin
          c_q     <= ram_rdata;
          state_q <= ST_WR_LO;
        end
        ST_WR_LO: begin
          d_q     <= ram_rdata;
          state_q <= ST_WR_HI;
        end
        ST_WR_HI: state_q <= ST_RESULT;
        ST_RESULT: begin
          if (out_free) begin
            out_q.out_index          <= item_q.coef_index;
            out_q.last               <= (item_q.coef_index == LAST_INDEX);
            if (item_q.resync) begin
              out_q.left_top_coef    <= def_q;
              out_q.above_left_coef  <= def_q;
              out_q.above_coef       <= def_q;
              out_q.above_right_coef <= def_q;
              out_q.left_bottom_coef <= def_q;
              state_q                <= ST_CLEAR;
            end else begin
              out_q.left_top_coef    <= col_nz ? item_q.prev_block1_coef : def_q;
              out_q.above_left_coef  <= b_q;
              out_q.above_coef       <= c_q;
              out_q.above_right_coef <= d_q;
              out_q.left_bottom_coef <= col_nz ? item_q.prev_block3_coef : def_q;
              state_q                <= ST_IDLE;
            end
          end
        end
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_cnt_q <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line store read and written in the same cycle");

  a_mod_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle remainder unit");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_B) |-> (col < w_q))
    else $error("column not below the picture width");

  a_waddr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < ADDR_W'(STORE_DEPTH)))
    else $error("line store write beyond its depth");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == ST_RESULT) |=> (state_q == ST_RESULT))
    else $error("result dropped while output stalled");

endmodule
